// File: hdl/msd_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and the seven-segment decode for the display driver.
// No dependencies.
package msd_pkg;

    localparam int ValueW = 27;
    localparam int SegW   = 8;
    localparam int DwellW = 16;
    localparam int EnW    = 8;
    localparam int BcdW   = 4;

    localparam logic [DwellW-1:0] DwellReset = DwellW'(2);

    // Request codes carried in req_type.
    localparam logic ReqTick = 1'b0;
    localparam logic ReqLoad = 1'b1;

    // Per-cycle control broadcast to every digit cell.
    typedef struct packed {
        logic clear;
        logic shift;
        logic load;
    } t_cell_ctrl;

    // Segments a..g in bits 0..6, decimal point (bit 7) never lit.
    function automatic logic [SegW-1:0] seg_of(input logic [BcdW-1:0] digit);
        logic [SegW-1:0] seg;
        case (digit)
            4'd0:    seg = 8'h3f;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5b;
            4'd3:    seg = 8'h4f;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6d;
            4'd6:    seg = 8'h7d;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7f;
            4'd9:    seg = 8'h6f;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// File: hdl/msd_in_if.sv
`timescale 1ns / 1ps
// Request channel of the display driver: tick or number write.
// Depends on msd_pkg for field widths.
interface msd_in_if;
    import msd_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [ValueW-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

// File: hdl/msd_out_if.sv
`timescale 1ns / 1ps
// Result channel of the display driver: segment pattern and digit enable.
// Depends on msd_pkg for field widths.
interface msd_out_if;
    import msd_pkg::*;

    logic            valid;
    logic            ready;
    logic [SegW-1:0] segments;
    logic [EnW-1:0]  digit_enable_n;

    modport source (output valid, output segments, output digit_enable_n, input ready);
    modport sink   (input valid, input segments, input digit_enable_n, output ready);
endinterface

// File: hdl/msd_digit_cell.sv
`timescale 1ns / 1ps
// One decimal digit of the shift-and-add-3 converter plus its displayed pattern.
// Depends on msd_pkg (t_cell_ctrl, seg_of).
module msd_digit_cell
    import msd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cell_ctrl      i_ctrl,
    input  logic            i_carry,
    output logic            o_carry,
    output logic [SegW-1:0] o_pattern
);

    logic [BcdW-1:0] r_digit;
    logic [BcdW-1:0] n_digit;
    logic [BcdW-1:0] w_adj;
    logic [SegW-1:0] r_pattern;

    // Pre-adjust so that doubling stays in decimal; the top bit carries out.
    assign w_adj   = (r_digit >= BcdW'(5)) ? r_digit + BcdW'(3) : r_digit;
    assign o_carry = w_adj[BcdW-1];

    always_comb begin
        n_digit = r_digit;
        if (i_ctrl.clear) begin
            n_digit = '0;
        end else if (i_ctrl.shift) begin
            n_digit = {w_adj[BcdW-2:0], i_carry};
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
        if (!i_rst_n) begin
            r_pattern <= '0;
        end else if (i_ctrl.load) begin
            r_pattern <= seg_of(r_digit);
        end
    end

    assign o_pattern = r_pattern;

endmodule

// File: hdl/multiplexed_seven_segment_display.sv
`timescale 1ns / 1ps
// Top level of the multiplexed seven-segment display driver.
// Depends on msd_pkg, msd_in_if, msd_out_if and msd_digit_cell.
//
// Usage:
//   i_in carries one beat per request: req_type 0 is a scan tick, req_type 1
//   loads value (27-bit unsigned) for display. Every request yields one beat
//   on o_out with the segment pattern and active-low enable of the lit digit.
//   i_cfg_we / i_cfg_wdata set the dwell in ticks; write only while idle.
// Timing:
//   A tick goes from acceptance through the result state to the result
//   register. A number write shifts one bit of value into the row of digit
//   cells per cycle, then the commit state latches the patterns and the result
//   state loads the result register. One request is in flight at a time; the
//   next is taken the cycle after the result is loaded.
// Reset:
//   Synchronous, active low. All patterns blank, scan at digit 0, dwell count
//   0, dwell 2 ticks.
// Stall:
//   A result waits in the output register until taken; a finished request
//   holds in its result state while that register is full.
module multiplexed_seven_segment_display
    import msd_pkg::*;
#(
    parameter int DIGIT_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    msd_in_if.sink            i_in,
    msd_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [DwellW-1:0] i_cfg_wdata
);

    localparam int PosW  = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CntW  = $clog2(ValueW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_COMMIT,
        ST_RESULT
    } t_state;

    t_state             r_state, n_state;
    logic [ValueW-1:0]  r_bin, n_bin;
    logic [CntW-1:0]    r_cnt, n_cnt;
    logic [PosW-1:0]    r_pos, n_pos;
    logic [DwellW-1:0]  r_dwell_count, n_dwell_count;
    logic [DwellW-1:0]  r_dwell_ticks;
    logic               r_out_valid, n_out_valid;
    logic [SegW-1:0]    r_seg, n_seg;
    logic [EnW-1:0]     r_en_n, n_en_n;

    logic               w_in_accept;
    logic               w_out_load;
    logic [DwellW-1:0]  w_count_inc;
    logic [EnW-1:0]     w_en_n;
    t_cell_ctrl         w_ctrl;
    logic               w_carry [DIGIT_COUNT];
    logic [SegW-1:0]    w_pat   [DIGIT_COUNT];

    assign i_in.ready   = (r_state == ST_IDLE);
    assign w_in_accept  = i_in.valid && i_in.ready;
    assign w_out_load   = (r_state == ST_RESULT) && (!r_out_valid || o_out.ready);
    assign w_count_inc  = r_dwell_count + DwellW'(1);

    assign w_ctrl.clear = w_in_accept && (i_in.req_type == ReqLoad);
    assign w_ctrl.shift = (r_state == ST_CONV);
    assign w_ctrl.load  = (r_state == ST_COMMIT);

    // Row of digit cells; MSB of the shifting value feeds digit 0.
    for (genvar g = 0; g < DIGIT_COUNT; g++) begin : g_cell
        msd_digit_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (w_ctrl),
            .i_carry   ((g == 0) ? r_bin[ValueW-1] : w_carry[(g == 0) ? 0 : g-1]),
            .o_carry   (w_carry[g]),
            .o_pattern (w_pat[g])
        );
    end

    always_comb begin
        for (int k = 0; k < EnW; k++) begin
            w_en_n[k] = !((k < DIGIT_COUNT) && (r_pos == PosW'(k)));
        end
    end

    always_comb begin
        n_state       = r_state;
        n_bin         = r_bin;
        n_cnt         = r_cnt;
        n_pos         = r_pos;
        n_dwell_count = r_dwell_count;
        n_out_valid   = r_out_valid;
        n_seg         = r_seg;
        n_en_n        = r_en_n;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    if (i_in.req_type == ReqLoad) begin
                        n_bin   = i_in.value;
                        n_cnt   = CntW'(ValueW - 1);
                        n_state = ST_CONV;
                    end else begin
                        n_dwell_count = w_count_inc;
                        if (w_count_inc >= r_dwell_ticks) begin
                            n_dwell_count = '0;
                            n_pos = (r_pos == PosW'(DIGIT_COUNT - 1)) ? '0
                                                                     : r_pos + PosW'(1);
                        end
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_CONV: begin
                // advance one bit per cycle into the cell row
                n_bin = {r_bin[ValueW-2:0], 1'b0};
                n_cnt = r_cnt - CntW'(1);
                if (r_cnt == '0) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                // hold until the output register is free
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_seg       = {1'b0, w_pat[r_pos][SegW-2:0]};
                    n_en_n      = w_en_n;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_cnt  <= n_cnt;
        r_seg  <= n_seg;
        r_en_n <= n_en_n;
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pos         <= '0;
            r_dwell_count <= '0;
            r_dwell_ticks <= DwellReset;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_pos         <= n_pos;
            r_dwell_count <= n_dwell_count;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                r_dwell_ticks <= i_cfg_wdata;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.segments       = r_seg;
    assign o_out.digit_enable_n = r_en_n;

    a_write_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_in.req_type == ReqLoad)) |=> (r_state == ST_CONV))
        else $error("number write did not start conversion");

    a_tick_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && (i_in.req_type == ReqTick)) |=> (r_state == ST_RESULT))
        else $error("tick did not go to result");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_pos} < (PosW+1)'(DIGIT_COUNT)))
        else $error("scan position out of range");

    a_result_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> (r_out_valid && (r_state == ST_IDLE)))
        else $error("result not loaded");

    a_commit_after_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_COMMIT) |-> ($past(r_state) == ST_CONV))
        else $error("commit without conversion");

endmodule

// File: tb/sv/tb_multiplexed_seven_segment_display.sv
`timescale 1ns / 1ps
// Self-checking bench for the eight-digit multiplexed display driver: a directed table, then
// random ticks and number writes under several dwell settings, checked against a scan model.
// Depends on msd_pkg, msd_in_if, msd_out_if and the multiplexed_seven_segment_display top.
module tb_multiplexed_seven_segment_display;
    import msd_pkg::*;

    localparam int Digits     = 8;
    localparam int HoldCycles = 200;
    localparam int Phases     = 10;
    localparam int PhaseItems = 145;
    localparam int DirRows    = 30;

    typedef enum logic { REQ_TICK = ReqTick, REQ_LOAD = ReqLoad } t_req_kind;
    typedef enum logic { ROW_REQ = 1'b0, ROW_DWELL = 1'b1 } t_row_kind;

    typedef struct packed {
        logic [SegW-1:0] segments;
        logic [EnW-1:0]  digit_enable_n;
    } t_display_beat;

    typedef struct packed {
        t_row_kind         kind;
        t_req_kind         req;
        logic [ValueW-1:0] value;
        logic [DwellW-1:0] dwell;
        logic              typed;
        logic [SegW-1:0]   exp_seg;
        logic [EnW-1:0]    exp_en;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [DwellW-1:0] i_cfg_wdata;

    msd_in_if  in_bus ();
    msd_out_if out_bus ();

    multiplexed_seven_segment_display #(
        .DIGIT_COUNT(Digits)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_bus),
        .o_out      (out_bus),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // Scan model state
    logic [SegW-1:0]   digit_glyph [10];
    logic [SegW-1:0]   glyph_store [Digits];
    int                scan_pos;
    logic [DwellW-1:0] dwell_cnt;
    logic [DwellW-1:0] dwell_len;

    t_display_beat beats_due [$];
    int  fail_count;
    int  beats_seen;
    int  loads_sent;
    int  ticks_sent;
    int  dwell_writes;
    bit  idle_on;
    bit  hold_request;
    int  rx_gap;

    t_dir_row dir_rows [DirRows] = '{
        '{ROW_REQ,   REQ_TICK, 27'h5555555, 16'd0,     1'b1, 8'h00, 8'hfe},
        '{ROW_REQ,   REQ_LOAD, 27'd0,       16'd0,     1'b1, 8'h3f, 8'hfe},
        '{ROW_REQ,   REQ_LOAD, 27'd134217727, 16'd0,   1'b1, 8'h07, 8'hfe},
        '{ROW_REQ,   REQ_LOAD, 27'd99999999, 16'd0,    1'b1, 8'h6f, 8'hfe},
        '{ROW_REQ,   REQ_LOAD, 27'd100000000, 16'd0,   1'b1, 8'h3f, 8'hfe},
        '{ROW_REQ,   REQ_LOAD, 27'd87654321, 16'd0,    1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'h2aaaaaa, 16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_DWELL, REQ_TICK, 27'd0,       16'd1,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_DWELL, REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_DWELL, REQ_TICK, 27'd0,       16'd10,    1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        // lower the dwell below the running count: the next tick must advance
        '{ROW_DWELL, REQ_TICK, 27'd0,       16'd3,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_LOAD, 27'd4096,    16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_DWELL, REQ_TICK, 27'd0,       16'd65535, 1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'h7ffffff, 16'd0,     1'b0, 8'h00, 8'h00},
        '{ROW_REQ,   REQ_TICK, 27'd0,       16'd0,     1'b0, 8'h00, 8'h00}
    };

    logic [DwellW-1:0] dwell_plan [Phases] = '{
        16'd1, 16'd2, 16'd0, 16'd3, 16'd65535, 16'd1, 16'd5, 16'd2, 16'd0, 16'd4
    };

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_display_beat predict_display(t_req_kind kind,
                                                      logic [ValueW-1:0] v);
        logic [31:0]   rest;
        t_display_beat beat;
        rest = 32'(v);
        if (kind == REQ_LOAD) begin
            for (int i = 0; i < Digits; i++) begin
                glyph_store[i] = digit_glyph[rest % 10];
                rest = rest / 10;
            end
        end else begin
            dwell_cnt = dwell_cnt + 1'b1;
            // a dwell of zero still advances, since the count is at least one here
            if (dwell_cnt >= dwell_len) begin
                dwell_cnt = '0;
                scan_pos  = (scan_pos == Digits - 1) ? 0 : scan_pos + 1;
            end
        end
        beat.segments       = glyph_store[scan_pos] & 8'h7f;
        beat.digit_enable_n = ~(EnW'(1) << scan_pos);
        return beat;
    endfunction

    function automatic void flag_error(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // Lower valid before any pause so the held beat is not taken twice.
    task automatic sender_idle();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
    endtask

    task automatic send_req(t_req_kind kind, logic [ValueW-1:0] v,
                            logic typed, t_display_beat fixed);
        int            gap;
        t_display_beat beat;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.req_type <= kind;
        in_bus.value    <= v;
        do @(posedge i_clk); while (!in_bus.ready);
        beat = predict_display(kind, v);
        beats_due.push_back(typed ? fixed : beat);
        if (kind == REQ_LOAD) loads_sent++;
        else ticks_sent++;
    endtask

    task automatic drain_results();
        while (beats_due.size() > 0) @(posedge i_clk);
    endtask

    task automatic write_dwell(logic [DwellW-1:0] d);
        sender_idle();
        drain_results();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= d;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        dwell_len = d;
        dwell_writes++;
    endtask

    function automatic logic [ValueW-1:0] draw_value();
        logic [ValueW-1:0] v;
        case ($urandom_range(0, 3))
            0: v = ValueW'($urandom);
            1: v = ValueW'($urandom_range(0, 99999999));
            2: v = ValueW'($urandom_range(0, 9999));
            default: begin
                case ($urandom_range(0, 3))
                    0: v = '0;
                    1: v = ValueW'(99999999);
                    2: v = ValueW'(100000000);
                    default: v = '1;
                endcase
            end
        endcase
        return v;
    endfunction

    // Result side: random gaps per beat plus one long hold on request.
    initial begin : result_sink
        int hold_left;
        hold_left     = 0;
        out_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HoldCycles;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_bus.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_display_beat want;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            beats_seen++;
            if (beats_due.size() == 0) begin
                flag_error($sformatf("unexpected beat seg=%02h en=%02h",
                                     out_bus.segments, out_bus.digit_enable_n));
            end else begin
                want = beats_due.pop_front();
                if (out_bus.segments !== want.segments)
                    flag_error($sformatf("beat %0d segments exp %02h got %02h",
                                         beats_seen, want.segments, out_bus.segments));
                if (out_bus.digit_enable_n !== want.digit_enable_n)
                    flag_error($sformatf("beat %0d digit_enable_n exp %02h got %02h",
                                         beats_seen, want.digit_enable_n,
                                         out_bus.digit_enable_n));
            end
            rx_gap = idle_on ? $urandom_range(0, 3) : 0;
        end
    end

    initial begin
        #5_000_000;
        $display("multiplexed_seven_segment_display: mismatch");
        $finish;
    end

    initial begin : stimulus
        t_display_beat     fixed;
        logic [ValueW-1:0] v;
        t_req_kind         kind;

        digit_glyph = '{8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66,
                        8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f};
        for (int i = 0; i < Digits; i++) glyph_store[i] = '0;
        scan_pos     = 0;
        dwell_cnt    = '0;
        dwell_len    = DwellReset;
        fail_count   = 0;
        beats_seen   = 0;
        loads_sent   = 0;
        ticks_sent   = 0;
        dwell_writes = 0;
        idle_on      = 1'b1;
        hold_request = 1'b0;
        rx_gap       = 0;

        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        in_bus.valid    = 1'b0;
        in_bus.req_type = REQ_TICK;
        in_bus.value    = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DirRows; r++) begin
            if (dir_rows[r].kind == ROW_DWELL) begin
                write_dwell(dir_rows[r].dwell);
            end else begin
                fixed.segments       = dir_rows[r].exp_seg;
                fixed.digit_enable_n = dir_rows[r].exp_en;
                send_req(dir_rows[r].req, dir_rows[r].value, dir_rows[r].typed, fixed);
            end
        end

        fixed = '0;
        for (int p = 0; p < Phases; p++) begin
            write_dwell(dwell_plan[p]);
            idle_on = (p % 3 != 2);
            for (int n = 0; n < PhaseItems; n++) begin
                if (p == 1 && n == 20) hold_request = 1'b1;
                if (p == 4 && n == 70) begin
                    sender_idle();
                    drain_results();
                end
                kind = ($urandom_range(0, 99) < 35) ? REQ_LOAD : REQ_TICK;
                // ticks carry a random value that the block must ignore
                v = (kind == REQ_LOAD) ? draw_value() : ValueW'($urandom);
                send_req(kind, v, 1'b0, fixed);
            end
        end

        sender_idle();
        drain_results();
        repeat (40) @(posedge i_clk);
        if (beats_due.size() > 0)
            flag_error($sformatf("%0d beats never arrived", beats_due.size()));

        $display("Run covered %0d number writes and %0d ticks over %0d dwell settings,",
                 loads_sent, ticks_sent, dwell_writes);
        $display("with %0d result beats checked and %0d errors.", beats_seen, fail_count);
        if (fail_count == 0) begin
            $display("multiplexed_seven_segment_display: match");
        end else begin
            $display("multiplexed_seven_segment_display: mismatch");
        end
        $finish;
    end

endmodule

// File: multiplexed_seven_segment_display.f
hdl/msd_pkg.sv
hdl/msd_in_if.sv
hdl/msd_out_if.sv
hdl/msd_digit_cell.sv
hdl/multiplexed_seven_segment_display.sv
tb/sv/tb_multiplexed_seven_segment_display.sv
